>>> src/sphere_pair_collision_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sphere pair collision unit
// Clocked, reset-qualified concurrent assertion wrapper.
// ----------------------------------------------------------------------------
`ifndef SPHERE_PAIR_COLLISION_UNIT_ASSERT_SVH
`define SPHERE_PAIR_COLLISION_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define SPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Invariant that must hold whenever its guard is high
`define SPC_ASSERT_WHEN(label, guard, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (guard) |-> (cond)) \
      else $error(msg);

`endif

>>> src/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Widths, stage payload types and step functions of the sphere pair unit.
// ----------------------------------------------------------------------------
package spc_pkg;

   localparam int CW    = 32;          // coordinate width
   localparam int MAGW  = CW + 1;      // magnitude of a centre difference
   localparam int SQW   = 2 * MAGW;    // sum of squares
   localparam int LW    = MAGW;        // integer square root
   localparam int SRW   = LW + 2;      // square root partial remainder
   localparam int RADW  = CW - 1;      // radius
   localparam int RSW   = CW;          // radius sum, penetration
   localparam int NW    = MAGW + RSW;  // dividend
   localparam int QW    = RSW;         // quotient
   localparam int DRW   = LW + 1;      // divider partial remainder
   localparam int XW    = CW + 3;      // signed working width of results

   typedef logic [CW-1:0]   coord_type;
   typedef logic [MAGW-1:0] mag_type;

   typedef struct packed {
      logic                 ev_a;
      logic                 ev_b;
      logic [2:0]           neg;
      coord_type [2:0]      pb;
      logic [RADW-1:0]      rb;
      logic [RSW-1:0]       rsum;
   } pair_type;

   typedef struct packed {
      logic [SQW-1:0] rad;
      logic [SRW-1:0] rem;
      logic [LW-1:0]  root;
   } sqrt_type;

   typedef struct packed {
      logic [NW-1:0]  num;
      logic [DRW-1:0] rem;
      logic [QW-1:0]  quo;
   } div_type;

   // one result bit of the digit-by-digit square root
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      logic [SRW-1:0] r;
      logic [SRW-1:0] t;
      sqrt_type       o;
      r     = {s.rem[SRW-3:0], s.rad[SQW-1:SQW-2]};
      t     = {s.root, 2'b01};
      o.rad = {s.rad[SQW-3:0], 2'b00};
      if (r >= t) begin
         o.rem  = r - t;
         o.root = {s.root[LW-2:0], 1'b1};
      end else begin
         o.rem  = r;
         o.root = {s.root[LW-2:0], 1'b0};
      end
      return o;
   endfunction

   // load a dividend whose quotient fits QW bits
   function automatic div_type div_init(input logic [NW-1:0] n);
      div_type o;
      o.rem = {1'b0, n[NW-1:QW]};
      o.num = {n[QW-1:0], {(NW-QW){1'b0}}};
      o.quo = '0;
      return o;
   endfunction

   // one quotient bit of the restoring divider
   function automatic div_type div_step(input div_type s, input logic [LW-1:0] dv);
      logic [DRW-1:0] r;
      div_type        o;
      r     = {s.rem[DRW-2:0], s.num[NW-1]};
      o.num = {s.num[NW-2:0], 1'b0};
      if (r >= {1'b0, dv}) begin
         o.rem = r - {1'b0, dv};
         o.quo = {s.quo[QW-2:0], 1'b1};
      end else begin
         o.rem = r;
         o.quo = {s.quo[QW-2:0], 1'b0};
      end
      return o;
   endfunction

   // clamp to the signed coordinate range
   function automatic coord_type sat_coord(input logic signed [XW-1:0] v);
      logic [XW-CW:0] top;
      coord_type      o;
      top = v[XW-1:CW-1];
      if (top == '0 || top == '1) begin
         o = v[CW-1:0];
      end else if (v[XW-1]) begin
         o = {1'b1, {(CW-1){1'b0}}};
      end else begin
         o = {1'b0, {(CW-1){1'b1}}};
      end
      return o;
   endfunction

endpackage

>>> src/sphere_pair_collision_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_collision_unit
// Pipelined narrow-phase sphere pair test with penetration push-out.
// ----------------------------------------------------------------------------
// Takes one sphere pair per cycle while the pipeline is not held. The stages
// are the registers for difference, squares and sum, the square root stages
// (one root bit per stage), the register for the six scaling multiplies,
// the divider stages (one quotient bit per stage) and saturation into the
// output register. A pair that raises events for both spheres occupies the
// output register for two beats, so the pipeline holds until the first beat
// is taken; pairs that do not overlap or raise no event produce no beat. The
// whole pipeline advances together and halts while the output is stalled.
`include "sphere_pair_collision_unit_assert.svh"

module sphere_pair_collision_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_pos_x, a_pos_y, a_pos_z, a_radius, a_layers, a_mask,
   // b_pos_x, b_pos_y, b_pos_z, b_radius, b_layers, b_mask, 2 pad bits
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // contact_x, contact_y, contact_z, push_x, push_y, push_z
   output logic [191:0] rsp_tdata,
   // target
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int CW   = spc_pkg::CW;
   localparam int LW   = spc_pkg::LW;
   localparam int QW   = spc_pkg::QW;
   localparam int XW   = spc_pkg::XW;
   localparam int RADW = spc_pkg::RADW;
   localparam int RSW  = spc_pkg::RSW;
   localparam int NW   = spc_pkg::NW;
   localparam int SQW  = spc_pkg::SQW;
   localparam int MAGW = spc_pkg::MAGW;
   localparam int SW   = 3 * CW + RADW + 2 * CW;   // one sphere in req_tdata

   logic en;

   // ---------------- stage 1: differences ----------------
   spc_pkg::pair_type   p_in;
   spc_pkg::mag_type    m_in [3];
   spc_pkg::pair_type   p1_ff;
   spc_pkg::mag_type    m1_ff [3];
   logic                v1_ff;

   logic [RADW-1:0] ra_w;
   logic [RADW-1:0] rb_w;

   assign ra_w = req_tdata[3*CW +: RADW];
   assign rb_w = req_tdata[SW + 3*CW +: RADW];

   always_comb begin
      logic signed [CW:0] d;
      p_in.rsum = {1'b0, ra_w} + {1'b0, rb_w};
      p_in.rb   = rb_w;
      p_in.ev_a = |(req_tdata[3*CW+RADW+CW +: CW] & req_tdata[SW+3*CW+RADW +: CW]);
      p_in.ev_b = |(req_tdata[SW+3*CW+RADW+CW +: CW] & req_tdata[3*CW+RADW +: CW]);
      for (int i = 0; i < 3; i++) begin
         d = $signed({req_tdata[i*CW+CW-1], req_tdata[i*CW +: CW]})
           - $signed({req_tdata[SW+i*CW+CW-1], req_tdata[SW+i*CW +: CW]});
         p_in.pb[i]  = req_tdata[SW+i*CW +: CW];
         p_in.neg[i] = d[CW];
         m_in[i]     = d[CW] ? MAGW'(-d) : MAGW'(d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         p1_ff <= p_in;
         m1_ff <= m_in;
      end
   end

   // ---------------- stage 2: squares ----------------
   spc_pkg::pair_type p2_ff;
   spc_pkg::mag_type  m2_ff [3];
   logic [SQW-1:0]    sq2_ff [3];
   logic              v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         p2_ff <= p1_ff;
         m2_ff <= m1_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= SQW'(m1_ff[i] * m1_ff[i]);
         end
      end
   end

   // ---------------- stage 3 and square root stages ----------------
   spc_pkg::sqrt_type sq_ff [LW+1];
   spc_pkg::pair_type ps_ff [LW+1];
   spc_pkg::mag_type  ms_ff [LW+1][3];
   logic              vs_ff [LW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff[0] <= 1'b0;
      end else if (en) begin
         vs_ff[0] <= v2_ff;
      end
      if (en) begin
         sq_ff[0].rad  <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
         sq_ff[0].rem  <= '0;
         sq_ff[0].root <= '0;
         ps_ff[0]      <= p2_ff;
         ms_ff[0]      <= m2_ff;
      end
   end

   for (genvar k = 1; k <= LW; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[k] <= 1'b0;
         end else if (en) begin
            vs_ff[k] <= vs_ff[k-1];
         end
         if (en) begin
            sq_ff[k] <= spc_pkg::sqrt_step(sq_ff[k-1]);
            ps_ff[k] <= ps_ff[k-1];
            ms_ff[k] <= ms_ff[k-1];
         end
      end
   end

   // ---------------- overlap test and scaling multiplies ----------------
   logic [LW-1:0]  len_w;
   logic           hit_w;
   logic [RSW-1:0] pen_w;

   assign len_w = sq_ff[LW].root;
   assign hit_w = len_w < {1'b0, ps_ff[LW].rsum};
   assign pen_w = ps_ff[LW].rsum - len_w[RSW-1:0];

   spc_pkg::div_type  dq_ff [QW+1][6];
   spc_pkg::pair_type pd_ff [QW+1];
   logic [LW-1:0]     dv_ff [QW+1];
   logic              zl_ff [QW+1];
   logic              vd_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff[0] <= 1'b0;
      end else if (en) begin
         vd_ff[0] <= vs_ff[LW] & hit_w;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dq_ff[0][i]   <= spc_pkg::div_init(NW'(ms_ff[LW][i] * pen_w));
            dq_ff[0][i+3] <= spc_pkg::div_init(NW'(ms_ff[LW][i] * {1'b0, ps_ff[LW].rb}));
         end
         pd_ff[0] <= ps_ff[LW];
         // coincident centres give zero magnitudes, so divide by one
         dv_ff[0] <= (len_w == '0) ? LW'(1) : len_w;
         zl_ff[0] <= (len_w == '0);
      end
   end

   // ---------------- divider stages ----------------
   for (genvar k = 1; k <= QW; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (en) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         if (en) begin
            for (int j = 0; j < 6; j++) begin
               dq_ff[k][j] <= spc_pkg::div_step(dq_ff[k-1][j], dv_ff[k-1]);
            end
            pd_ff[k] <= pd_ff[k-1];
            dv_ff[k] <= dv_ff[k-1];
            zl_ff[k] <= zl_ff[k-1];
         end
      end
   end

   // ---------------- signs, contact point, saturation ----------------
   spc_pkg::coord_type contact_in [3];
   spc_pkg::coord_type push_a_in  [3];
   spc_pkg::coord_type push_b_in  [3];

   always_comb begin
      logic signed [XW-1:0] sp;
      logic signed [XW-1:0] sr;
      logic signed [XW-1:0] c;
      for (int i = 0; i < 3; i++) begin
         sp = $signed({3'b000, dq_ff[QW][i].quo});
         sr = $signed({3'b000, dq_ff[QW][i+3].quo});
         if (pd_ff[QW].neg[i]) begin
            sp = -sp;
            sr = -sr;
         end
         c = $signed({{(XW-CW){pd_ff[QW].pb[i][CW-1]}}, pd_ff[QW].pb[i]}) + sr - sp;
         contact_in[i] = spc_pkg::sat_coord(c);
         push_a_in[i]  = spc_pkg::sat_coord(sp);
         push_b_in[i]  = spc_pkg::sat_coord(-sp);
      end
   end

   // ---------------- output register ----------------
   spc_pkg::coord_type contact_ff [3];
   spc_pkg::coord_type push_a_ff  [3];
   spc_pkg::coord_type push_b_ff  [3];
   logic               pend_a_ff;
   logic               pend_b_ff;

   // advance when the output register empties this cycle
   assign en = !(pend_a_ff || pend_b_ff) || (rsp_tready && !(pend_a_ff && pend_b_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
      end else if (en) begin
         pend_a_ff <= vd_ff[QW] & pd_ff[QW].ev_a;
         pend_b_ff <= vd_ff[QW] & pd_ff[QW].ev_b;
      end else if (rsp_tready) begin
         // first of two beats taken, the second sphere's beat follows
         pend_a_ff <= 1'b0;
      end
      if (en) begin
         contact_ff <= contact_in;
         push_a_ff  <= push_a_in;
         push_b_ff  <= push_b_in;
      end
   end

   assign req_tready   = en;
   assign rsp_tvalid   = pend_a_ff | pend_b_ff;
   assign rsp_tuser[0] = !pend_a_ff;
   assign rsp_tlast    = !(pend_a_ff && pend_b_ff);
   assign rsp_tdata    = {
      pend_a_ff ? push_a_ff[2] : push_b_ff[2],
      pend_a_ff ? push_a_ff[1] : push_b_ff[1],
      pend_a_ff ? push_a_ff[0] : push_b_ff[0],
      contact_ff[2], contact_ff[1], contact_ff[0]
   };

   // ---------------- assertions ----------------
   `SPC_ASSERT(a_second_beat, (pend_a_ff && pend_b_ff && rsp_tready) |=> (rsp_tvalid && rsp_tuser[0] && rsp_tlast), "second event must follow the first")
   `SPC_ASSERT_WHEN(a_div_rem, vd_ff[QW], dq_ff[QW][0].rem < {1'b0, dv_ff[QW]}, "divider remainder not below divisor")
   `SPC_ASSERT_WHEN(a_zero_len, vd_ff[QW] && zl_ff[QW], dq_ff[QW][0].quo == '0 && dq_ff[QW][3].quo == '0, "coincident centres must give zero push")

endmodule
